// ===== rtl/core/srt_pkg.sv =====
// srt_pkg: shared types and codes for the sorted ranking table
// entry layout, command and status codes, field widths
// no dependencies
package srt_pkg;

   localparam int RANK_W = 6;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LIST   = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_LISTED   = 2'd2,
      ST_NOMATCH  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  player;
      logic [7:0]  partner;
      logic [15:0] points;
      logic [1:0]  level;
      logic        kind;
      logic [7:0]  wins;
      logic [7:0]  losses;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/core/srt_if.sv =====
// srt_if: valid/ready channels of the sorted ranking table
// request channel (commands) and response channel (results)
// depends on srt_pkg
interface srt_req_if;
   logic                  valid;
   logic                  ready;
   srt_pkg::command_type  command;
   logic [7:0]            player_id;
   logic [7:0]            partner_id;
   logic [15:0]           points;
   logic [1:0]            level;
   logic                  kind;
   logic [7:0]            wins;
   logic [7:0]            losses;

   modport source (output valid, command, player_id, partner_id, points, level, kind,
                   wins, losses, input ready);
   modport sink (input valid, command, player_id, partner_id, points, level, kind,
                 wins, losses, output ready);
endinterface

interface srt_rsp_if;
   logic                         valid;
   logic                         ready;
   srt_pkg::status_type          status;
   logic [srt_pkg::RANK_W-1:0]   rank;
   logic [7:0]                   out_player;
   logic [7:0]                   out_partner;
   logic [15:0]                  out_points;
   logic [7:0]                   out_wins;
   logic [7:0]                   out_losses;
   logic                         last;

   modport source (output valid, status, rank, out_player, out_partner, out_points,
                   out_wins, out_losses, last, input ready);
   modport sink (input valid, status, rank, out_player, out_partner, out_points,
                 out_wins, out_losses, last, output ready);
endinterface

// ===== rtl/core/srt_ram.sv =====
// srt_ram: generic single-write, single-read synchronous ram
// registered read, rd_data follows rd_addr in the cycle after rd_en; read data holds while rd_en is low
// no dependencies
module srt_ram #(
   parameter int WIDTH = 51,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sorted_ranking_table.sv =====
// sorted_ranking_table: bounded table of entries kept in descending order of points
// depends on srt_pkg, srt_if (srt_req_if, srt_rsp_if) and srt_ram
//
// usage
//   req carries one command word: insert places a new entry ahead of the first
//   stored entry with strictly fewer points (ties keep arrival order); list
//   streams every stored entry whose level and kind match, in table order
//   rsp carries result words: one status word per insert (inserted or full),
//   one listed word per matching entry with rank from 1, or a single no-match
//   word; the final word of every command has last set
// timing
//   the table lives in one ram with a registered read
//   insert: backward scan from the tail, one entry read and shifted per cycle;
//     no entry is read on an empty or a full table
//   list: forward scan, one entry read per cycle while rsp is not stalled
//   one command at a time; req is ready only between commands
// reset
//   synchronous, clears the entry count and control; ram contents are not
//   cleared, entries beyond the count are never read
// stall
//   results leave through an output register; while rsp is stalled a
//   second match stops the list scan and the ram read data simply holds
module sorted_ranking_table #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   srt_req_if.sink     req,
   srt_rsp_if.source   rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISCAN,
      S_LSCAN,
      S_FINISH
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;       // insert: free slot; list: next read
   logic                 rv_ff, rv_in;         // ram read data valid this cycle
   logic                 held_v_ff, held_v_in;
   logic [CW-1:0]        nmatch_ff, nmatch_in;
   srt_pkg::status_type  status_ff, status_in;
   logic                 rsp_v_ff, rsp_v_in;

   // payload
   srt_pkg::entry_type   new_ff, new_in;       // insert entry, or list selector
   srt_pkg::entry_type   held_ff, held_in;     // latest match, sent once next is known
   srt_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [srt_pkg::RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   srt_pkg::entry_type   rsp_entry_ff, rsp_entry_in;
   logic                 rsp_last_ff, rsp_last_in;

   // ram side
   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   srt_pkg::entry_type        wr_data, rdata;
   logic [srt_pkg::ENTRY_W-1:0] rd_bits;

   logic [CW-1:0] idx_m1, idx_m2;
   logic          out_free, match, stall;

   srt_ram #(
      .WIDTH (srt_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rdata    = srt_pkg::entry_type'(rd_bits);
   assign idx_m1   = idx_ff - CW'(1);
   assign idx_m2   = idx_ff - CW'(2);
   assign out_free = !rsp_v_ff || rsp.ready;
   assign match    = (rdata.level == new_ff.level) && (rdata.kind == new_ff.kind);
   // a second match needs the output register for the one held
   assign stall    = rv_ff && match && held_v_ff && !out_free;

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rv_in         = 1'b0;
      held_v_in     = held_v_ff;
      nmatch_in     = nmatch_ff;
      status_in     = status_ff;
      new_in        = new_ff;
      held_in       = held_ff;
      rsp_v_in      = rsp_v_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = new_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               new_in.player  = req.player_id;
               new_in.partner = req.partner_id;
               new_in.points  = req.points;
               new_in.level   = req.level;
               new_in.kind    = req.kind;
               new_in.wins    = req.wins;
               new_in.losses  = req.losses;
               held_v_in      = 1'b0;
               nmatch_in      = '0;
               if (req.command == srt_pkg::CMD_INSERT) begin
                  if (count_ff >= CW'(DEPTH)) begin
                     status_in = srt_pkg::ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     status_in = srt_pkg::ST_INSERTED;
                     idx_in    = count_ff;
                     state_in  = S_ISCAN;
                  end
               end else begin
                  status_in = srt_pkg::ST_NOMATCH;
                  idx_in    = '0;
                  state_in  = S_LSCAN;
               end
            end
         end

         S_ISCAN: begin
            if (rv_ff) begin
               if (new_ff.points > rdata.points) begin
                  // shift the smaller entry one slot toward the tail
                  wr_en   = 1'b1;
                  wr_data = rdata;
                  idx_in  = idx_m1;
                  if (idx_ff != CW'(1)) begin
                     rd_en   = 1'b1;
                     rd_addr = idx_m2[AW-1:0];
                     rv_in   = 1'b1;
                  end
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  state_in = S_FINISH;
               end
            end else if (idx_ff == '0) begin
               // new entry goes to the head
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = S_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_m1[AW-1:0];
               rv_in   = 1'b1;
            end
         end

         S_LSCAN: begin
            if (stall) begin
               rv_in = 1'b1;
            end else begin
               if (rv_ff && match) begin
                  if (held_v_ff) begin
                     rsp_v_in      = 1'b1;
                     rsp_status_in = srt_pkg::ST_LISTED;
                     rsp_rank_in   = srt_pkg::RANK_W'(nmatch_ff);
                     rsp_entry_in  = held_ff;
                     rsp_last_in   = 1'b0;
                  end
                  held_in   = rdata;
                  held_v_in = 1'b1;
                  nmatch_in = nmatch_ff + CW'(1);
               end
               if (idx_ff < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff[AW-1:0];
                  idx_in  = idx_ff + CW'(1);
                  rv_in   = 1'b1;
               end else if (!rv_ff) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_last_in = 1'b1;
               if (held_v_ff) begin
                  rsp_status_in = srt_pkg::ST_LISTED;
                  rsp_rank_in   = srt_pkg::RANK_W'(nmatch_ff);
                  rsp_entry_in  = held_ff;
               end else begin
                  rsp_status_in = status_ff;
                  rsp_rank_in   = '0;
                  rsp_entry_in  = '0;
               end
               held_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         rv_ff     <= 1'b0;
         held_v_ff <= 1'b0;
         nmatch_ff <= '0;
         status_ff <= srt_pkg::ST_INSERTED;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rv_ff     <= rv_in;
         held_v_ff <= held_v_in;
         nmatch_ff <= nmatch_in;
         status_ff <= status_in;
         rsp_v_ff  <= rsp_v_in;
      end
      new_ff        <= new_in;
      held_ff       <= held_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid       = rsp_v_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.rank        = rsp_rank_ff;
   assign rsp.out_player  = rsp_entry_ff.player;
   assign rsp.out_partner = rsp_entry_ff.partner;
   assign rsp.out_points  = rsp_entry_ff.points;
   assign rsp.out_wins    = rsp_entry_ff.wins;
   assign rsp.out_losses  = rsp_entry_ff.losses;
   assign rsp.last        = rsp_last_ff;

   // shift writes and the next read never hit the same slot
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("ram read and write at the same address");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // the count only grows, one entry per completed insert
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count changed by more than one");

   a_held_has_rank: assert property (@(posedge clock) disable iff (reset)
      held_v_ff |-> (nmatch_ff != '0))
      else $error("held match without a match count");

endmodule
